// ===== src/itoa_pkg.sv =====
// itoa_pkg: shared types and character codes for the integer to decimal text converter
// no dependencies
package itoa_pkg;

    typedef logic [7:0] char_t;

    localparam int    COUNT_W    = 4;
    localparam char_t CHAR_ZERO  = 8'd48;
    localparam char_t CHAR_MINUS = 8'd45;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// signed_int_to_decimal_ascii_top: signed integer to decimal ascii text, one character per strobe
// depends on itoa_pkg
//
// Pulse start while busy is low to hand in one item (value, two's complement). The text
// comes out one character per strobe, most significant first, with '-' ahead of a negative
// value and no leading zeros; last flags the final character and char_count then holds the
// total. The receiver cannot stall: every strobe lasts one cycle and must be taken. An item
// is handled in steps, the '-' overlapping the conversion: first it is loaded, then the
// magnitude goes through a shift-add-3 binary to BCD register one bit per cycle, then leading
// zero digits are dropped and the rest emitted, one digit per cycle each. busy falls while the
// last character is out, so the next start is taken at the edge that ends it.
module signed_int_to_decimal_ascii_top
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   strobe,
    output logic [7:0]             ascii_char,
    output logic [COUNT_W-1:0]     char_count,
    output logic                   last
);

    // decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BW   = $clog2(VALUE_WIDTH);
    localparam int DW   = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [NDIG*4-1:0]      bcd_reg, bcd_next;
    logic [NDIG*4-1:0]      bcd_adj;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0]          dig_cnt_reg, dig_cnt_next;
    count_t                 count_reg, count_next;
    logic                   strobe_reg, strobe_next;
    char_t                  char_reg, char_next;
    count_t                 cnt_out_reg, cnt_out_next;
    logic                   last_reg, last_next;
    logic [3:0]             top_digit;
    logic                   neg;

    assign neg       = value[VALUE_WIDTH-1];
    assign top_digit = bcd_reg[NDIG*4-1 -: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        count_next   = count_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        cnt_out_next = cnt_out_reg;
        last_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mag_next     = neg ? (~value + VALUE_WIDTH'(1)) : value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                    // the sign goes out right away, ahead of the digits
                    strobe_next  = neg;
                    char_next    = CHAR_MINUS;
                    cnt_out_next = count_t'(1);
                    count_next   = neg ? count_t'(1) : count_t'(0);
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[NDIG*4-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BW'(1);
                if (bit_cnt_reg == BW'(VALUE_WIDTH - 1))
                begin
                    dig_cnt_next = DW'(NDIG);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && dig_cnt_reg != DW'(1))
                begin
                    bcd_next     = {bcd_reg[NDIG*4-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DW'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next  = 1'b1;
                char_next    = CHAR_ZERO + {4'd0, top_digit};
                cnt_out_next = count_reg + count_t'(1);
                count_next   = count_reg + count_t'(1);
                last_next    = (dig_cnt_reg == DW'(1));
                bcd_next     = {bcd_reg[NDIG*4-5:0], 4'd0};
                dig_cnt_next = dig_cnt_reg - DW'(1);
                if (dig_cnt_reg == DW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        count_reg   <= count_next;
        char_reg    <= char_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign char_count = cnt_out_reg;
    assign last       = last_reg;

    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("block still busy after final character");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (ascii_char == CHAR_MINUS)
                || (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_ZERO + 8'd9))
        else $error("character outside sign and digits");

    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && ascii_char == CHAR_MINUS |-> char_count == count_t'(1) && !last)
        else $error("sign not leading the text");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item not taken");

endmodule
